[hdl/rlvd_pkg.sv]
// rlvd_pkg: shared constants and types for the varint run-length decoder.
// No dependencies; used by rle_varint_decoder_top.
package rlvd_pkg;

  localparam int CFG_LEN_W = 17;
  localparam int RES_LIMIT = 32;
  localparam int RES_CNT_W = 6;

  // register index of stream_length on the APB port
  localparam logic REG_STREAM_LENGTH = 1'b0;

  // decode phases
  localparam logic [2:0] PH_V0  = 3'd0;
  localparam logic [2:0] PH_V1  = 3'd1;
  localparam logic [2:0] PH_V2  = 3'd2;
  localparam logic [2:0] PH_LIT = 3'd3;
  localparam logic [2:0] PH_VAL = 3'd4;
  localparam logic [2:0] PH_CNT = 3'd5;
  localparam logic [2:0] PH_ALL = 3'd6;

  // what one compressed byte leaves to be emitted
  typedef struct packed {
    logic       lit;       // one literal byte
    logic [7:0] run_cnt;   // copies of the repeat value
    logic       tail;      // trailing marker word (error or empty end)
    logic       err;       // malformed stream
    logic       fin;       // fragment ends with this byte
  } plan_t;

endpackage

[hdl/rle_varint_decoder_top.sv]
// rle_varint_decoder_top: run-length decoder with varint offsets for one fragment.
// Depends on rlvd_pkg.
//
// A fragment starts when stream_length is written; its bytes then arrive on
// in_byte. Each accepted byte is decoded, and the results it causes are
// then emitted one per cycle while out_stall stays low, from a single run
// packer that fills up to OUT_LANES copies per word and counts the run down.
// A varint or value byte causes no result, a literal byte one, and a count
// byte up to ceil(count/OUT_LANES) run words, at most RES_LIMIT. An error or
// an empty fragment end adds one status word. in_stall stays high until the
// last result of the byte has been loaded into the output register, so
// output stalls hold off the next byte. Errors end the fragment with a
// status word; later bytes of that fragment are swallowed.
module rle_varint_decoder_top #(
  parameter int MAX_LENGTH = 65536,
  parameter int OUT_LANES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  // compressed byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        run_end,
  output logic        done_res,
  output logic        status,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);

  // decode state
  logic [rlvd_pkg::CFG_LEN_W-1:0] stream_length;
  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] bytes_left;
  logic [15:0]      offset_accum, offset_accum_next;
  logic [15:0]      literal_left, literal_left_next;
  logic [7:0]       repeat_value, repeat_value_next;
  logic             aborted;

  // pending results of the current byte
  logic                          lit_pend;
  logic [7:0]                    lit_byte;
  logic [7:0]                    run_left;
  logic [rlvd_pkg::RES_CNT_W-1:0] run_words;
  logic                          tail_pend;
  logic                          tail_err;
  logic                          fin;

  rlvd_pkg::plan_t plan;

  logic in_xfer, cfg_wr, busy, run_active, emit_go;
  logic [LEN_W-1:0] rem;
  logic [31:0] cfg_raw;
  logic        cfg_sat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == rlvd_pkg::REG_STREAM_LENGTH);
  assign prdata   = (paddr[2] == rlvd_pkg::REG_STREAM_LENGTH) ?
                    {{(32-rlvd_pkg::CFG_LEN_W){1'b0}}, stream_length} : 32'd0;
  assign cfg_raw  = {{(32-rlvd_pkg::CFG_LEN_W){1'b0}}, pwdata[rlvd_pkg::CFG_LEN_W-1:0]};
  assign cfg_sat  = cfg_raw > 32'(MAX_LENGTH);

  assign run_active = (run_left != 8'd0) &&
                      (32'(run_words) < 32'(rlvd_pkg::RES_LIMIT));
  assign busy       = lit_pend || run_active || tail_pend;
  assign in_stall   = busy;
  assign in_xfer    = in_valid && !in_stall;
  assign emit_go    = busy && (!out_valid || !out_stall);
  assign rem        = bytes_left - LEN_W'(1);

  // decode of one byte: next phase and the results it owes
  always_comb begin
    logic [15:0] oa;
    logic [15:0] delta;
    logic        do_finish;
    logic        do_enter;
    phase_next        = phase;
    offset_accum_next = offset_accum;
    literal_left_next = literal_left;
    repeat_value_next = repeat_value;
    plan              = '0;
    oa                = offset_accum;
    do_finish         = 1'b0;
    do_enter          = 1'b0;
    delta             = 16'd0;
    case (phase)
      rlvd_pkg::PH_V0: begin
        if (rem == '0) begin
          plan.err = 1'b1;
        end else begin
          oa = {9'd0, in_byte[6:0]};
          if (in_byte[7]) phase_next = rlvd_pkg::PH_V1;
          else            do_finish  = 1'b1;
        end
      end
      rlvd_pkg::PH_V1: begin
        oa = offset_accum | {2'd0, in_byte[6:0], 7'd0};
        if (in_byte[7]) begin
          if (rem == '0) plan.err   = 1'b1;
          else           phase_next = rlvd_pkg::PH_V2;
        end else begin
          do_finish = 1'b1;
        end
      end
      rlvd_pkg::PH_V2: begin
        oa = offset_accum | {in_byte[1:0], 14'd0};
        if (in_byte[7]) plan.err  = 1'b1;
        else            do_finish = 1'b1;
      end
      rlvd_pkg::PH_LIT: begin
        plan.lit          = 1'b1;
        literal_left_next = literal_left - 16'd1;
        if (literal_left_next == 16'd0) do_enter = 1'b1;
      end
      rlvd_pkg::PH_VAL: begin
        repeat_value_next = in_byte;
        phase_next        = rlvd_pkg::PH_CNT;
      end
      rlvd_pkg::PH_CNT: begin
        plan.run_cnt = in_byte;
        phase_next   = rlvd_pkg::PH_V0;
      end
      rlvd_pkg::PH_ALL: begin
        plan.lit = 1'b1;
      end
      default: begin
        phase_next = rlvd_pkg::PH_V0;
      end
    endcase
    offset_accum_next = oa;
    if (do_finish) begin
      delta = oa - 16'd1;
      if (oa == 16'd0) begin
        phase_next = rlvd_pkg::PH_ALL;
      end else if (32'(delta) > 32'(rem)) begin
        plan.err = 1'b1;
      end else if (delta != 16'd0) begin
        literal_left_next = delta;
        phase_next        = rlvd_pkg::PH_LIT;
      end else begin
        do_enter = 1'b1;
      end
    end
    if (do_enter) begin
      if (32'(rem) < 32'd2) plan.err   = 1'b1;
      else                  phase_next = rlvd_pkg::PH_VAL;
    end
    plan.fin  = plan.err || (rem == '0);
    plan.tail = plan.err || ((rem == '0) && !plan.lit && (plan.run_cnt == 8'd0));
  end

  // result selection: literal, then run words, then the marker word
  logic [3:0]  lanes;
  logic [63:0] run_word;
  logic [7:0]  run_left_after;
  logic        run_more;
  logic        more_after;
  logic [63:0] res_bytes;
  logic [3:0]  res_count;
  logic        res_status;

  always_comb begin
    lanes = (run_left < 8'(OUT_LANES)) ? run_left[3:0] : 4'(OUT_LANES);
    for (int i = 0; i < 8; i++) begin
      run_word[i*8 +: 8] = (4'(i) < lanes) ? repeat_value : 8'd0;
    end
    run_left_after = run_left - {4'd0, lanes};
    run_more       = (run_left_after != 8'd0) &&
                     (32'(run_words) + 32'd1 < 32'(rlvd_pkg::RES_LIMIT));
    if (lit_pend) begin
      res_bytes  = {56'd0, lit_byte};
      res_count  = 4'd1;
      res_status = 1'b0;
      more_after = run_active || tail_pend;
    end else if (run_active) begin
      res_bytes  = run_word;
      res_count  = lanes;
      res_status = 1'b0;
      more_after = run_more || tail_pend;
    end else begin
      res_bytes  = 64'd0;
      res_count  = 4'd0;
      res_status = tail_err;
      more_after = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= '0;
      phase         <= rlvd_pkg::PH_V0;
      bytes_left    <= '0;
      offset_accum  <= '0;
      literal_left  <= '0;
      repeat_value  <= '0;
      aborted       <= 1'b0;
      lit_pend      <= 1'b0;
      run_left      <= '0;
      run_words     <= '0;
      tail_pend     <= 1'b0;
      tail_err      <= 1'b0;
      fin           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        stream_length <= cfg_sat ? rlvd_pkg::CFG_LEN_W'(MAX_LENGTH)
                                 : pwdata[rlvd_pkg::CFG_LEN_W-1:0];
        bytes_left    <= cfg_sat ? LEN_W'(MAX_LENGTH) : LEN_W'(cfg_raw);
        phase         <= rlvd_pkg::PH_V0;
        offset_accum  <= '0;
        literal_left  <= '0;
        repeat_value  <= '0;
        aborted       <= 1'b0;
      end else if (in_xfer && (bytes_left != '0)) begin
        bytes_left <= rem;
        if (!aborted) begin
          phase        <= phase_next;
          offset_accum <= offset_accum_next;
          literal_left <= literal_left_next;
          repeat_value <= repeat_value_next;
          aborted      <= plan.err;
          lit_pend     <= plan.lit;
          lit_byte     <= in_byte;
          run_left     <= plan.run_cnt;
          run_words    <= '0;
          tail_pend    <= plan.tail;
          tail_err     <= plan.err;
          fin          <= plan.fin;
        end
      end

      if (emit_go) begin
        out_valid <= 1'b1;
        out_bytes <= res_bytes;
        out_count <= res_count;
        status    <= res_status;
        run_end   <= !more_after;
        done_res  <= !more_after && fin;
        if (lit_pend) begin
          lit_pend <= 1'b0;
        end else if (run_active) begin
          run_left  <= run_more ? run_left_after : 8'd0;
          run_words <= run_words + rlvd_pkg::RES_CNT_W'(1);
        end else begin
          tail_pend <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (done_res && run_end && (out_count == 4'd0)))
    else $error("error word carries data or is not final");

  a_lane_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_count) <= 32'(OUT_LANES)))
    else $error("more lanes than OUT_LANES");

  a_lit_run_excl: assert property (@(posedge clk) disable iff (rst)
    !(lit_pend && (run_left != 8'd0)))
    else $error("literal and run pending together");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    32'(run_words) <= 32'(rlvd_pkg::RES_LIMIT))
    else $error("run emitted beyond result limit");

  a_done_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> run_end)
    else $error("fragment end on a non-final word");
`endif

endmodule
